// ===== rtl/wsip_pkg.sv =====
package wsip_pkg;

    localparam int SPEED_W       = 16;
    localparam int ERR_W         = SPEED_W + 1;
    localparam int DP_W          = ERR_W + 1;
    localparam int DD_W          = ERR_W + 2;
    localparam int GAIN_W        = 16;
    localparam int PROD_W        = GAIN_W + 1 + DD_W;
    localparam int DELTA_W       = PROD_W + 2;
    localparam int ACC_W         = 48;
    localparam int OUT_W         = 32;
    localparam int FRAC_BITS_DEF = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int NUM_STAGES    = 6;

    localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = 16'd640;
    localparam logic [GAIN_W-1:0] GAIN_INTEG_RST = 16'd51;
    localparam logic [GAIN_W-1:0] GAIN_DERIV_RST = 16'd384;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 2'd2;

    typedef struct packed {
        logic [GAIN_W-1:0] prop;
        logic [GAIN_W-1:0] integ;
        logic [GAIN_W-1:0] deriv;
    } t_gains;

    // one load enable per pipeline stage
    typedef struct packed {
        logic ld_in;
        logic ld_err;
        logic ld_prod;
        logic ld_delta;
        logic ld_acc;
        logic ld_out;
    } t_stage_en;

endpackage

// ===== rtl/wsip_in_if.sv =====
interface wsip_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [wsip_pkg::SPEED_W-1:0] left_speed;
    logic signed [wsip_pkg::SPEED_W-1:0] right_speed;

    modport source (output valid, left_speed, right_speed, input ready);
    modport sink   (input valid, left_speed, right_speed, output ready);
endinterface

// ===== rtl/wsip_out_if.sv =====
interface wsip_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [wsip_pkg::OUT_W-1:0] correction;

    modport source (output valid, correction, input ready);
    modport sink   (input valid, correction, output ready);
endinterface

// ===== rtl/wsip_cfg_if.sv =====
interface wsip_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [wsip_pkg::CFG_IDX_W-1:0]     index;
    logic [wsip_pkg::GAIN_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/wsip_cfg_regs.sv =====
module wsip_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wsip_cfg_if.sink          i_cfg,
    output wsip_pkg::t_gains  o_gains
);

    wsip_pkg::t_gains r_gains;

    assign i_cfg.ready = 1'b1;
    assign o_gains     = r_gains;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.prop  <= wsip_pkg::GAIN_PROP_RST;
            r_gains.integ <= wsip_pkg::GAIN_INTEG_RST;
            r_gains.deriv <= wsip_pkg::GAIN_DERIV_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                wsip_pkg::REG_GAIN_PROP:  r_gains.prop  <= i_cfg.data;
                wsip_pkg::REG_GAIN_INTEG: r_gains.integ <= i_cfg.data;
                wsip_pkg::REG_GAIN_DERIV: r_gains.deriv <= i_cfg.data;
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

endmodule

// ===== rtl/wsip_pipe_ctl.sv =====
module wsip_pipe_ctl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_out_ready,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output wsip_pkg::t_stage_en  o_en
);

    localparam int N = wsip_pkg::NUM_STAGES;

    logic [N-1:0] r_vld;
    logic [N-1:0] n_vld;
    logic [N-1:0] rdy;
    logic [N-1:0] prev;
    logic [N-1:0] ld;

    // a stage can take a new item when it is empty or its item moves on
    always_comb begin
        rdy[N-1] = !r_vld[N-1] || i_out_ready;
        for (int k = N - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign prev  = {r_vld[N-2:0], i_in_valid};
    assign ld    = rdy & prev;
    assign n_vld = (rdy & prev) | (~rdy & r_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_ready  = rdy[0];
    assign o_out_valid = r_vld[N-1];

    assign o_en.ld_in    = ld[0];
    assign o_en.ld_err   = ld[1];
    assign o_en.ld_prod  = ld[2];
    assign o_en.ld_delta = ld[3];
    assign o_en.ld_acc   = ld[4];
    assign o_en.ld_out   = ld[5];

endmodule

// ===== rtl/wsip_err.sv =====
module wsip_err (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  wsip_pkg::t_stage_en                i_en,
    input  logic signed [wsip_pkg::SPEED_W-1:0] i_left,
    input  logic signed [wsip_pkg::SPEED_W-1:0] i_right,
    output logic signed [wsip_pkg::ERR_W-1:0]   o_err,
    output logic signed [wsip_pkg::DP_W-1:0]    o_dp,
    output logic signed [wsip_pkg::DD_W-1:0]    o_dd
);

    localparam int EW = wsip_pkg::ERR_W;

    logic signed [wsip_pkg::SPEED_W-1:0] r_left;
    logic signed [wsip_pkg::SPEED_W-1:0] r_right;
    logic signed [EW-1:0]                r_held;
    logic signed [EW-1:0]                r_prev1;
    logic signed [EW-1:0]                r_prev2;
    logic signed [EW-1:0]                r_err;
    logic signed [wsip_pkg::DP_W-1:0]    r_dp;
    logic signed [wsip_pkg::DD_W-1:0]    r_dd;

    logic signed [EW-1:0]                left_x;
    logic signed [EW-1:0]                right_x;
    logic        [EW-1:0]                mag_l;
    logic        [EW-1:0]                mag_r;
    logic                                mag_eq;
    logic signed [EW-1:0]                n_err;
    logic signed [wsip_pkg::DP_W-1:0]    n_dp;
    logic signed [wsip_pkg::DD_W-1:0]    n_dd;

    always_ff @(posedge i_clk) begin
        if (i_en.ld_in) begin
            r_left  <= i_left;
            r_right <= i_right;
        end
    end

    assign left_x  = EW'(r_left);
    assign right_x = EW'(r_right);
    assign mag_l   = r_left[wsip_pkg::SPEED_W-1]  ? -left_x  : left_x;
    assign mag_r   = r_right[wsip_pkg::SPEED_W-1] ? -right_x : right_x;
    assign mag_eq  = (mag_l == mag_r);

    // equal magnitudes: reuse the last held sum
    assign n_err = mag_eq ? r_held : (left_x + right_x);
    assign n_dp  = wsip_pkg::DP_W'(n_err) - wsip_pkg::DP_W'(r_prev1);
    assign n_dd  = wsip_pkg::DD_W'(n_err) - (wsip_pkg::DD_W'(r_prev1) <<< 1)
                 + wsip_pkg::DD_W'(r_prev2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_prev1 <= '0;
            r_prev2 <= '0;
        end else if (i_en.ld_err) begin
            if (!mag_eq) begin
                r_held <= left_x + right_x;
            end
            r_prev2 <= r_prev1;
            r_prev1 <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld_err) begin
            r_err <= n_err;
            r_dp  <= n_dp;
            r_dd  <= n_dd;
        end
    end

    assign o_err = r_err;
    assign o_dp  = r_dp;
    assign o_dd  = r_dd;

endmodule

// ===== rtl/wsip_mac.sv =====
module wsip_mac (
    input  logic                                i_clk,
    input  wsip_pkg::t_stage_en                 i_en,
    input  wsip_pkg::t_gains                    i_gains,
    input  logic signed [wsip_pkg::ERR_W-1:0]   i_err,
    input  logic signed [wsip_pkg::DP_W-1:0]    i_dp,
    input  logic signed [wsip_pkg::DD_W-1:0]    i_dd,
    output logic signed [wsip_pkg::DELTA_W-1:0] o_delta
);

    localparam int PW = wsip_pkg::PROD_W;
    localparam int DW = wsip_pkg::DELTA_W;

    logic signed [wsip_pkg::GAIN_W:0] kp;
    logic signed [wsip_pkg::GAIN_W:0] ki;
    logic signed [wsip_pkg::GAIN_W:0] kd;
    logic signed [PW-1:0]             n_pp;
    logic signed [PW-1:0]             n_pi;
    logic signed [PW-1:0]             n_pd;
    logic signed [PW-1:0]             r_pp;
    logic signed [PW-1:0]             r_pi;
    logic signed [PW-1:0]             r_pd;
    logic signed [DW-1:0]             r_delta;

    // gains are unsigned: widen with a zero sign bit
    assign kp = {1'b0, i_gains.prop};
    assign ki = {1'b0, i_gains.integ};
    assign kd = {1'b0, i_gains.deriv};

    assign n_pp = PW'(kp) * PW'(i_dp);
    assign n_pi = PW'(ki) * PW'(i_err);
    assign n_pd = PW'(kd) * PW'(i_dd);

    always_ff @(posedge i_clk) begin
        if (i_en.ld_prod) begin
            r_pp <= n_pp;
            r_pi <= n_pi;
            r_pd <= n_pd;
        end
        if (i_en.ld_delta) begin
            r_delta <= DW'(r_pp) + DW'(r_pi) + DW'(r_pd);
        end
    end

    assign o_delta = r_delta;

endmodule

// ===== rtl/wsip_acc.sv =====
module wsip_acc #(
    parameter int FRAC_BITS = wsip_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wsip_pkg::t_stage_en                 i_en,
    input  wsip_pkg::t_gains                    i_gains,
    input  logic signed [wsip_pkg::DELTA_W-1:0] i_delta,
    output logic signed [wsip_pkg::OUT_W-1:0]   o_correction
);

    localparam int AW = wsip_pkg::ACC_W;
    localparam int OW = wsip_pkg::OUT_W;

    localparam logic [AW-1:0] FRAC_MASK = (AW'(1) << FRAC_BITS) - AW'(1);
    localparam logic signed [AW-1:0] Q_MAX =
        {{(AW - OW + 1){1'b0}}, {(OW - 1){1'b1}}};
    localparam logic signed [AW-1:0] Q_MIN =
        {{(AW - OW + 1){1'b1}}, {(OW - 1){1'b0}}};

    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] n_acc;
    logic signed [AW:0]   sum;
    logic                 gains_zero;
    logic signed [AW-1:0] q_floor;
    logic signed [AW-1:0] q_inc;
    logic signed [AW-1:0] q;
    logic signed [OW-1:0] n_out;
    logic signed [OW-1:0] r_out;

    assign gains_zero = (i_gains.prop == '0) && (i_gains.integ == '0)
                     && (i_gains.deriv == '0);

    assign sum = (AW + 1)'(r_acc) + (AW + 1)'(i_delta);

    // clear when all gains are zero; else saturate when the two top bits of the sum disagree
    always_comb begin
        if (gains_zero) begin
            n_acc = '0;
        end else if (sum[AW] != sum[AW-1]) begin
            n_acc = {sum[AW], {(AW - 1){~sum[AW]}}};
        end else begin
            n_acc = sum[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_en.ld_acc) begin
            r_acc <= n_acc;
        end
    end

    // shift floors; bump negative values with a remainder to truncate toward zero
    assign q_floor = r_acc >>> FRAC_BITS;
    assign q_inc   = {{(AW - 1){1'b0}}, r_acc[AW-1] && ((r_acc & FRAC_MASK) != '0)};
    assign q       = q_floor + q_inc;

    always_comb begin
        if (q > Q_MAX) begin
            n_out = Q_MAX[OW-1:0];
        end else if (q < Q_MIN) begin
            n_out = Q_MIN[OW-1:0];
        end else begin
            n_out = q[OW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.ld_out) begin
            r_out <= n_out;
        end
    end

    assign o_correction = r_out;

endmodule

// ===== rtl/wheel_sync_incremental_pid_unit.sv =====
// Wheel synchronization controller: incremental PID on the speed sum of two
// opposed drive wheels.
//
// i_in carries one sample (left_speed, right_speed) per transfer; o_out
// returns one correction per sample, in order. i_cfg writes the three gains
// (index 0 proportional, 1 integral, 2 derivative, unsigned fixed point with
// FRAC_BITS fraction bits); write them only while no sample is in flight.
// i_cfg.ready is always high.
//
// The datapath is a six-stage pipeline: input, error history, gain products,
// increment sum, saturating accumulator, output; samples pass through them in
// that order. One sample can be taken every cycle while o_out is not stalled;
// each stage holds its item only while the stage after it is full and cannot
// move on, so a stalled receiver fills the bubbles before i_in.ready drops.
//
// Reset loads the default gains, clears the error history and the
// accumulator, and empties the pipeline.
module wheel_sync_incremental_pid_unit #(
    parameter int FRAC_BITS = wsip_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wsip_in_if.sink     i_in,
    wsip_out_if.source  o_out,
    wsip_cfg_if.sink    i_cfg
);

    wsip_pkg::t_gains                     gains;
    wsip_pkg::t_stage_en                  en;
    logic signed [wsip_pkg::ERR_W-1:0]    err;
    logic signed [wsip_pkg::DP_W-1:0]     dp;
    logic signed [wsip_pkg::DD_W-1:0]     dd;
    logic signed [wsip_pkg::DELTA_W-1:0]  delta;

    wsip_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_gains (gains)
    );

    wsip_pipe_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_en        (en)
    );

    wsip_err u_err (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_left  (i_in.left_speed),
        .i_right (i_in.right_speed),
        .o_err   (err),
        .o_dp    (dp),
        .o_dd    (dd)
    );

    wsip_mac u_mac (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_gains (gains),
        .i_err   (err),
        .i_dp    (dp),
        .i_dd    (dd),
        .o_delta (delta)
    );

    wsip_acc #(
        .FRAC_BITS (FRAC_BITS)
    ) u_acc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_gains      (gains),
        .i_delta      (delta),
        .o_correction (o_out.correction)
    );

endmodule
